FILE: hw/rtl/asu_pkg.sv
// Shared types, constants and helpers for the agent steering update pipeline.
`timescale 1ns / 1ps

package asu_pkg;

    localparam int SQRT_STAGES = 16;
    localparam int DIV_STAGES  = 15;
    localparam int SIDE_LEN    = SQRT_STAGES + DIV_STAGES + 2;
    localparam int MAG_STAGE   = SQRT_STAGES + 1;

    // 1/sqrt(2) in Q0.16
    localparam logic [15:0] INV_SQRT2 = 16'd46341;
    // ceil(2^24 / 10), exact floor division by ten for values below 419430
    localparam logic [20:0] RECIP_TEN = 21'd1677722;

    localparam logic [2:0] REG_ARENA_LEFT    = 3'd0;
    localparam logic [2:0] REG_ARENA_RIGHT   = 3'd1;
    localparam logic [2:0] REG_ARENA_TOP     = 3'd2;
    localparam logic [2:0] REG_ARENA_BOTTOM  = 3'd3;
    localparam logic [2:0] REG_WALL_MARGIN   = 3'd4;
    localparam logic [2:0] REG_DELETE_MARGIN = 3'd5;
    localparam logic [2:0] REG_DESIRED_SPEED = 3'd6;
    localparam logic [2:0] REG_MAX_ACCEL     = 3'd7;

    typedef struct packed {
        logic               valid;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [1:0]  dirx;
        logic signed [1:0]  diry;
        logic               neg_x;
        logic               neg_y;
    } side_t;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767)
            return 16'sh7fff;
        else if (v < -18'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
        if (v > 25'sd8388607)
            return 24'sh7fffff;
        else if (v < -25'sd8388608)
            return 24'sh800000;
        else
            return v[23:0];
    endfunction

endpackage

FILE: hw/rtl/asu_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module asu_sqrt
    import asu_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] radicand,
    output logic [15:0] root
);

    logic [32:0] x_reg [SQRT_STAGES];
    logic [32:0] r_reg [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic [32:0] x_in;
        logic [32:0] r_in;
        logic [32:0] bitv;
        logic [32:0] trial;
        logic        take;

        if (k == 0) begin : g_first
            assign x_in = {1'b0, radicand};
            assign r_in = '0;
        end else begin : g_rest
            assign x_in = x_reg[k-1];
            assign r_in = r_reg[k-1];
        end

        assign bitv  = 33'd1 << (2 * (SQRT_STAGES - 1 - k));
        assign trial = r_in + bitv;
        assign take  = (x_in >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k] <= take ? (x_in - trial) : x_in;
                r_reg[k] <= take ? ((r_in >> 1) + bitv) : (r_in >> 1);
            end
        end
    end

    assign root = r_reg[SQRT_STAGES-1][15:0];

endmodule

FILE: hw/rtl/asu_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module asu_div
    import asu_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [30:0] num,
    input  logic [15:0] den,
    output logic [14:0] quo
);

    logic [30:0] rem_reg [DIV_STAGES];
    logic [15:0] den_reg [DIV_STAGES];
    logic [14:0] q_reg   [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [30:0] rem_in;
        logic [15:0] den_in;
        logic [14:0] q_in;
        logic [30:0] dsh;
        logic        take;

        if (k == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign q_in   = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        assign dsh  = 31'(den_in) << (DIV_STAGES - 1 - k);
        assign take = (rem_in >= dsh);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= take ? (rem_in - dsh) : rem_in;
                den_reg[k] <= den_in;
                q_reg[k]   <= {q_in[13:0], take};
            end
        end
    end

    assign quo = q_reg[DIV_STAGES-1];

endmodule

FILE: hw/rtl/agent_steering_update.sv
// Top level: steering agent update pipeline with configuration registers.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid / in_ready   | pos_x, pos_y, vel_x, vel_y
//  out     | out_valid / out_ready | new_pos_x, new_pos_y, new_vel_x, new_vel_y,
//          |                       | remove
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One agent per cycle while the output is not stalled.
// The pipeline runs through the 16-stage square root and the 15-stage divider.
// Reset empties the pipeline and loads the default register values.
// A stalled output freezes the whole pipeline; in_ready drops with it.
`timescale 1ns / 1ps

module agent_steering_update
    import asu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    input  logic signed [15:0] vel_x,
    input  logic signed [15:0] vel_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [23:0] new_pos_x,
    output logic signed [23:0] new_pos_y,
    output logic signed [15:0] new_vel_x,
    output logic signed [15:0] new_vel_y,
    output logic               remove,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [14:0]        cfg_data
);

    logic [11:0] left_reg, right_reg, top_reg, bottom_reg;
    logic [7:0]  wall_margin_reg, delete_margin_reg;
    logic [14:0] desired_speed_reg, max_accel_reg;
    logic [14:0] diag_accel_reg;
    logic [30:0] diag_prod;

    logic en;

    side_t side_reg [SIDE_LEN];
    side_t side_in;
    side_t mag_side;
    logic [31:0] sqx_reg, sqy_reg;
    logic [15:0] mag;
    logic signed [16:0] diff_raw, diff_clamp;
    logic signed [32:0] prod_x, prod_y;
    logic signed [32:0] prod_x_reg, prod_y_reg;
    logic [15:0] den_reg;
    logic [30:0] num_x, num_y;
    logic [14:0] quo_x, quo_y;

    logic signed [25:0] lim_xlo, lim_xhi, lim_ylo, lim_yhi;
    logic signed [25:0] del_xlo, del_xhi, del_ylo, del_yhi;

    // final stages
    side_t f1_reg, f2_reg, f3_reg;
    side_t f3_next;
    logic [18:0] ax_reg, ay_reg;
    logic        sx_reg, sy_reg, sx2_reg, sy2_reg;
    logic [39:0] mx_reg, my_reg;
    logic signed [15:0] sfx, sfy, wfx, wfy, wmag;
    logic signed [20:0] tx, ty;
    logic [20:0] tax, tay;
    logic signed [16:0] dvx, dvy;
    logic signed [23:0] npx, npy;
    logic               rem_flag;
    logic               out_valid_reg;
    logic signed [23:0] npx_reg, npy_reg;
    logic signed [15:0] nvx_reg, nvy_reg;
    logic               remove_reg;

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg          <= 12'd20;
            right_reg         <= 12'd1260;
            top_reg           <= 12'd44;
            bottom_reg        <= 12'd444;
            wall_margin_reg   <= 8'd40;
            delete_margin_reg <= 8'd20;
            desired_speed_reg <= 15'd768;
            max_accel_reg     <= 15'd64;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ARENA_LEFT:    left_reg          <= cfg_data[11:0];
                REG_ARENA_RIGHT:   right_reg         <= cfg_data[11:0];
                REG_ARENA_TOP:     top_reg           <= cfg_data[11:0];
                REG_ARENA_BOTTOM:  bottom_reg        <= cfg_data[11:0];
                REG_WALL_MARGIN:   wall_margin_reg   <= cfg_data[7:0];
                REG_DELETE_MARGIN: delete_margin_reg <= cfg_data[7:0];
                REG_DESIRED_SPEED: desired_speed_reg <= cfg_data;
                REG_MAX_ACCEL:     max_accel_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // diagonal wall push: round(max_accel / sqrt(2)), registered
    assign diag_prod = 31'(max_accel_reg) * 31'(INV_SQRT2) + 31'd32768;

    always_ff @(posedge clk)
    begin
        diag_accel_reg <= diag_prod[30:16];
    end

    assign lim_xlo = $signed({6'd0, left_reg, 8'd0}) + $signed({10'd0, wall_margin_reg, 8'd0});
    assign lim_xhi = $signed({6'd0, right_reg, 8'd0}) - $signed({10'd0, wall_margin_reg, 8'd0});
    assign lim_ylo = $signed({6'd0, top_reg, 8'd0}) + $signed({10'd0, wall_margin_reg, 8'd0});
    assign lim_yhi = $signed({6'd0, bottom_reg, 8'd0}) - $signed({10'd0, wall_margin_reg, 8'd0});
    assign del_xlo = $signed({6'd0, left_reg, 8'd0}) - $signed({10'd0, delete_margin_reg, 8'd0});
    assign del_xhi = $signed({6'd0, right_reg, 8'd0}) + $signed({10'd0, delete_margin_reg, 8'd0});
    assign del_ylo = $signed({6'd0, top_reg, 8'd0}) - $signed({10'd0, delete_margin_reg, 8'd0});
    assign del_yhi = $signed({6'd0, bottom_reg, 8'd0}) + $signed({10'd0, delete_margin_reg, 8'd0});

    always_comb
    begin
        side_in       = '0;
        side_in.valid = in_valid;
        side_in.px    = pos_x;
        side_in.py    = pos_y;
        side_in.vx    = vel_x;
        side_in.vy    = vel_y;
        side_in.dirx  = 2'(($signed(26'(pos_x)) < lim_xlo) ? 1 : 0)
                      - 2'(($signed(26'(pos_x)) > lim_xhi) ? 1 : 0);
        side_in.diry  = 2'(($signed(26'(pos_y)) < lim_ylo) ? 1 : 0)
                      - 2'(($signed(26'(pos_y)) > lim_yhi) ? 1 : 0);
    end

    // speed force: |v| clamped difference times v, ready for the divider
    assign diff_raw   = $signed({2'b0, desired_speed_reg}) - $signed({1'b0, mag});
    assign diff_clamp = (diff_raw > $signed({2'b0, max_accel_reg}))
                      ? $signed({2'b0, max_accel_reg})
                      : ((diff_raw < -$signed({2'b0, max_accel_reg}))
                         ? -$signed({2'b0, max_accel_reg}) : diff_raw);
    assign prod_x = 33'(side_reg[SQRT_STAGES].vx) * 33'(diff_clamp);
    assign prod_y = 33'(side_reg[SQRT_STAGES].vy) * 33'(diff_clamp);

    // product signs ride along to the end of the divider
    always_comb
    begin
        mag_side       = side_reg[MAG_STAGE-1];
        mag_side.neg_x = prod_x[32];
        mag_side.neg_y = prod_y[32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SIDE_LEN; i++)
                side_reg[i] <= '0;
        end
        else if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < SIDE_LEN; i++)
                side_reg[i] <= (i == MAG_STAGE) ? mag_side : side_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg    <= 32'($signed(32'(vel_x)) * $signed(32'(vel_x)));
            sqy_reg    <= 32'($signed(32'(vel_y)) * $signed(32'(vel_y)));
            prod_x_reg <= prod_x;
            prod_y_reg <= prod_y;
            // zero velocity: divide zero by one so the force stays zero
            den_reg    <= (mag == 16'd0) ? 16'd1 : mag;
        end
    end

    asu_sqrt u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand (sqx_reg + sqy_reg),
        .root     (mag)
    );

    // rounding half away from zero: |p| + mag/2, then floor divide
    assign num_x = (prod_x_reg[32] ? 31'(-prod_x_reg) : prod_x_reg[30:0]) + 31'(den_reg >> 1);
    assign num_y = (prod_y_reg[32] ? 31'(-prod_y_reg) : prod_y_reg[30:0]) + 31'(den_reg >> 1);

    asu_div u_div_x (
        .clk (clk),
        .en  (en),
        .num (num_x),
        .den (den_reg),
        .quo (quo_x)
    );

    asu_div u_div_y (
        .clk (clk),
        .en  (en),
        .num (num_y),
        .den (den_reg),
        .quo (quo_y)
    );

    // F1: combine speed and wall force, take magnitude for the divide by ten
    always_comb
    begin
        sfx  = side_reg[SIDE_LEN-1].neg_x ? -$signed({1'b0, quo_x}) : $signed({1'b0, quo_x});
        sfy  = side_reg[SIDE_LEN-1].neg_y ? -$signed({1'b0, quo_y}) : $signed({1'b0, quo_y});
        wmag = (side_reg[SIDE_LEN-1].dirx != 2'sd0 && side_reg[SIDE_LEN-1].diry != 2'sd0)
             ? $signed({1'b0, diag_accel_reg}) : $signed({1'b0, max_accel_reg});
        wfx  = (side_reg[SIDE_LEN-1].dirx == 2'sd1) ? wmag
             : ((side_reg[SIDE_LEN-1].dirx == -2'sd1) ? -wmag : 16'sd0);
        wfy  = (side_reg[SIDE_LEN-1].diry == 2'sd1) ? wmag
             : ((side_reg[SIDE_LEN-1].diry == -2'sd1) ? -wmag : 16'sd0);
        tx   = 21'(sfx) * 21'sd2 + 21'(wfx) * 21'sd8;
        ty   = 21'(sfy) * 21'sd2 + 21'(wfy) * 21'sd8;
        tax  = (tx < 0) ? 21'(-tx) : 21'(tx);
        tay  = (ty < 0) ? 21'(-ty) : 21'(ty);
    end

    // F3 and F4 arithmetic
    assign dvx = sx2_reg ? -$signed({1'b0, mx_reg[39:24]}) : $signed({1'b0, mx_reg[39:24]});
    assign dvy = sy2_reg ? -$signed({1'b0, my_reg[39:24]}) : $signed({1'b0, my_reg[39:24]});
    assign npx = sat24(25'(f3_reg.px) + 25'(f3_reg.vx));
    assign npy = sat24(25'(f3_reg.py) + 25'(f3_reg.vy));
    assign rem_flag = ($signed(26'(npx)) < del_xlo) || ($signed(26'(npx)) > del_xhi)
                   || ($signed(26'(npy)) < del_ylo) || ($signed(26'(npy)) > del_yhi);

    always_comb
    begin
        f3_next    = f2_reg;
        f3_next.vx = sat16(18'(f2_reg.vx) + 18'(dvx));
        f3_next.vy = sat16(18'(f2_reg.vy) + 18'(dvy));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_reg        <= '0;
            f2_reg        <= '0;
            f3_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_reg        <= side_reg[SIDE_LEN-1];
            f2_reg        <= f1_reg;
            f3_reg        <= f3_next;
            out_valid_reg <= f3_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg     <= 19'(tax + 21'd5);
            ay_reg     <= 19'(tay + 21'd5);
            sx_reg     <= tx[20];
            sy_reg     <= ty[20];
            mx_reg     <= 40'(ax_reg) * 40'(RECIP_TEN);
            my_reg     <= 40'(ay_reg) * 40'(RECIP_TEN);
            sx2_reg    <= sx_reg;
            sy2_reg    <= sy_reg;
            npx_reg    <= npx;
            npy_reg    <= npy;
            nvx_reg    <= f3_reg.vx;
            nvy_reg    <= f3_reg.vy;
            remove_reg <= rem_flag;
        end
    end

    assign out_valid = out_valid_reg;
    assign new_pos_x = npx_reg;
    assign new_pos_y = npy_reg;
    assign new_vel_x = nvx_reg;
    assign new_vel_y = nvy_reg;
    assign remove    = remove_reg;

endmodule

FILE: hw/rtl/asu_checker.sv
// Port-level checks for the steering update block, bound to the top level.
`timescale 1ns / 1ps

module asu_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [23:0] new_pos_x,
    input logic signed [15:0] new_vel_x,
    input logic               cfg_ready
);

    // a held result keeps its x position and x velocity
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(new_pos_x) && $stable(new_vel_x))
        else $error("output changed while stalled");

    // input side runs exactly when the output side can move
    a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow the output stall");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid right after reset");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind agent_steering_update asu_checker u_asu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .new_pos_x (new_pos_x),
    .new_vel_x (new_vel_x),
    .cfg_ready (cfg_ready)
);

FILE: bench/tb.sv
// Self-checking bench for the agent steering update pipeline.
`timescale 1ns / 1ps

module tb;
    import asu_pkg::*;

    typedef struct {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
    } agent_t;

    typedef struct {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic               rem;
    } update_t;

    // directed row: agent, and a typed-in expectation where it is obvious
    typedef struct {
        agent_t  a;
        bit      known;
        update_t u;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic               out_valid;
    logic               out_ready;
    logic signed [23:0] new_pos_x;
    logic signed [23:0] new_pos_y;
    logic signed [15:0] new_vel_x;
    logic signed [15:0] new_vel_y;
    logic               remove;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [14:0]        cfg_data;

    agent_steering_update DUT (.*);

    // shadow copy of the register file
    longint left_e, right_e, top_e, bottom_e, wall_m, del_m, speed_goal, accel_lim;

    update_t pending_updates[$];
    int      errors;
    int      in_idle_pct;
    int      out_idle_pct;
    int      n_checked;
    longint  cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint int_sqrt(longint x);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > x)
            b = b >>> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint div_round(longint num, longint den);
        longint a;
        longint q;
        a = num < 0 ? -num : num;
        q = (a + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic longint clip(longint v, int w);
        longint hi;
        hi = (64'sd1 <<< (w - 1)) - 1;
        return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
    endfunction

    function automatic update_t steer(agent_t a);
        update_t u;
        longint px, py, vx, vy, le, re, te, be, wm, dm;
        longint dx, dy, wfx, wfy, sfx, sfy, mag, diff, d, nvx, nvy, npx, npy;
        px = longint'(a.px); py = longint'(a.py);
        vx = longint'(a.vx); vy = longint'(a.vy);
        le = left_e * 256; re = right_e * 256; te = top_e * 256; be = bottom_e * 256;
        wm = wall_m * 256; dm = del_m * 256;
        dx = 0; dy = 0; sfx = 0; sfy = 0;
        if (px < le + wm) dx += 1;
        if (px > re - wm) dx -= 1;
        if (py < te + wm) dy += 1;
        if (py > be - wm) dy -= 1;
        if (dx != 0 && dy != 0)
        begin
            d = (accel_lim * 46341 + 32768) >>> 16;
            wfx = dx * d;
            wfy = dy * d;
        end
        else
        begin
            wfx = dx * accel_lim;
            wfy = dy * accel_lim;
        end
        mag = int_sqrt(vx * vx + vy * vy);
        if (mag != 0)
        begin
            diff = speed_goal - mag;
            if (diff > accel_lim) diff = accel_lim;
            if (diff < -accel_lim) diff = -accel_lim;
            sfx = div_round(vx * diff, mag);
            sfy = div_round(vy * diff, mag);
        end
        nvx = clip(vx + div_round(2 * sfx + 8 * wfx, 10), 16);
        nvy = clip(vy + div_round(2 * sfy + 8 * wfy, 10), 16);
        npx = clip(px + nvx, 24);
        npy = clip(py + nvy, 24);
        u.px = 24'(npx); u.py = 24'(npy); u.vx = 16'(nvx); u.vy = 16'(nvy);
        u.rem = npx < le - dm || npx > re + dm || npy < te - dm || npy > be + dm;
        return u;
    endfunction

    function automatic agent_t rand_agent(bit near_arena);
        agent_t a;
        longint span_x;
        longint span_y;
        span_x = (right_e - left_e + 600) * 256;
        span_y = (bottom_e - top_e + 600) * 256;
        if (span_x <= 0) span_x = 1000;
        if (span_y <= 0) span_y = 1000;
        if (near_arena)
        begin
            a.px = 24'((left_e - 300) * 256
                       + longint'($urandom_range(0, 32'(span_x))));
            a.py = 24'((top_e - 300) * 256
                       + longint'($urandom_range(0, 32'(span_y))));
            a.vx = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
            a.vy = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
        end
        else
        begin
            a.px = 24'($urandom);
            a.py = 24'($urandom);
            a.vx = 16'($urandom);
            a.vy = 16'($urandom);
        end
        if ($urandom_range(0, 19) == 0)
        begin
            a.vx = 0;
            a.vy = 0;
        end
        return a;
    endfunction

    // output side: random stalls, compare in order
    always @(posedge clk)
    begin
        update_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_updates.size() == 0)
            begin
                $display("%0t: unexpected output pos=(%0d,%0d) vel=(%0d,%0d) rem=%0b", $time,
                         new_pos_x, new_pos_y, new_vel_x, new_vel_y, remove);
                errors++;
            end
            else
            begin
                e = pending_updates.pop_front();
                n_checked++;
                if (new_pos_x !== e.px || new_pos_y !== e.py || new_vel_x !== e.vx
                    || new_vel_y !== e.vy || remove !== e.rem)
                begin
                    $display("%0t: mismatch expected pos=(%0d,%0d) vel=(%0d,%0d) rem=%0b",
                             $time, e.px, e.py, e.vx, e.vy, e.rem);
                    $display("%0t:          actual   pos=(%0d,%0d) vel=(%0d,%0d) rem=%0b",
                             $time, new_pos_x, new_pos_y, new_vel_x, new_vel_y, remove);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
        if (rst_n)
            out_ready <= ($urandom_range(0, 99) >= out_idle_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, longint val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 15'(val);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ARENA_LEFT:    left_e     = val & 12'hfff;
            REG_ARENA_RIGHT:   right_e    = val & 12'hfff;
            REG_ARENA_TOP:     top_e      = val & 12'hfff;
            REG_ARENA_BOTTOM:  bottom_e   = val & 12'hfff;
            REG_WALL_MARGIN:   wall_m     = val & 8'hff;
            REG_DELETE_MARGIN: del_m      = val & 8'hff;
            REG_DESIRED_SPEED: speed_goal = val & 15'h7fff;
            default:           accel_lim  = val & 15'h7fff;
        endcase
    endtask

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_agent(agent_t a);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pos_x <= a.px; pos_y <= a.py; vel_x <= a.vx; vel_y <= a.vy;
        pending_updates.push_back(steer(a));
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_updates.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load_regs(longint l, longint r, longint t, longint b, longint wm,
                             longint dm, longint sp, longint ac);
        write_reg(REG_ARENA_LEFT, l);
        write_reg(REG_ARENA_RIGHT, r);
        write_reg(REG_ARENA_TOP, t);
        write_reg(REG_ARENA_BOTTOM, b);
        write_reg(REG_WALL_MARGIN, wm);
        write_reg(REG_DELETE_MARGIN, dm);
        write_reg(REG_DESIRED_SPEED, sp);
        write_reg(REG_MAX_ACCEL, ac);
    endtask

    initial
    begin
        row_t   rows[$];
        row_t   r;
        agent_t a;
        int     phase;
        int     k;

        errors = 0; n_checked = 0; cycles = 0;
        in_idle_pct = 0; out_idle_pct = 0;
        left_e = 20; right_e = 1260; top_e = 44; bottom_e = 444;
        wall_m = 40; del_m = 20; speed_goal = 768; accel_lim = 64;
        rst_n = 1'b0; in_valid = 1'b0; out_ready = 1'b0; cfg_valid = 1'b0;
        cfg_index = REG_ARENA_LEFT; cfg_data = '0;
        pos_x = '0; pos_y = '0; vel_x = '0; vel_y = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // at reset defaults: center at rest stays put; saturation corners
        r.known = 1'b1;
        r.a = '{24'sd160000, 24'sd60000, 16'sd0, 16'sd0};
        r.u = '{24'sd160000, 24'sd60000, 16'sd0, 16'sd0, 1'b0};
        rows.push_back(r);
        r.a = '{24'sh7fffff, 24'sh7fffff, 16'sh7fff, 16'sh7fff};
        r.known = 1'b0;
        rows.push_back(r);
        r.a = '{24'sh800000, 24'sh800000, 16'sh8000, 16'sh8000};
        rows.push_back(r);
        r.a = '{24'sh800000, 24'sh7fffff, 16'sh7fff, 16'sh8000};
        rows.push_back(r);
        r.a = '{24'sd0, 24'sd0, 16'sd0, 16'sd0};        // both walls push
        rows.push_back(r);
        r.a = '{24'sd10240, 24'sd60000, 16'sd768, 16'sd0}; // inside left wall margin
        rows.push_back(r);
        r.a = '{24'sd312320, 24'sd103424, 16'sd0, 16'sd256};
        rows.push_back(r);
        r.a = '{24'sd160000, 24'sd60000, 16'sd100, -16'sd50};
        rows.push_back(r);
        r.a = '{24'sd160000, 24'sd60000, -16'sd3000, 16'sd3000};
        rows.push_back(r);
        r.a = '{24'sd317000, 24'sd118000, 16'sd0, 16'sd0}; // right and bottom walls push
        rows.push_back(r);
        foreach (rows[i])
        begin
            send_agent(rows[i].a);
            if (rows[i].known)
                pending_updates[$] = rows[i].u;
        end
        drain();

        // crossed edges with huge margins and limits, then full edges with zero ones
        load_regs(4095, 0, 4095, 0, 255, 255, 32767, 32767);
        for (k = 0; k < 12; k++) send_agent(rand_agent(k[0]));
        drain();
        load_regs(0, 4095, 0, 4095, 0, 0, 0, 0);
        for (k = 0; k < 12; k++) send_agent(rand_agent(k[0]));
        drain();

        for (phase = 0; phase < 3; phase++)
        begin
            in_idle_pct  = phase == 0 ? 31 : (phase == 1 ? 82 : 0);
            out_idle_pct = phase == 0 ? 82 : (phase == 1 ? 31 : 0);
            load_regs($urandom_range(0, 400), $urandom_range(600, 4095),
                      $urandom_range(0, 400), $urandom_range(500, 4095),
                      $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 3000), $urandom_range(0, 600));
            for (k = 0; k < 225; k++)
            begin
                if (k == 100)
                begin
                    in_valid <= 1'b0;
                    while (pending_updates.size() != 0) @(posedge clk);
                    @(negedge clk);
                end
                a = rand_agent($urandom_range(0, 9) < 8);
                send_agent(a);
            end
            drain();
        end

        $display("tb: %0d agent updates checked over directed, extreme and random settings",
                 n_checked);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
